/* design/eegfd_pkg.sv */
// Shared constants, types and decode function for the EEG frame deframer and unpacker.
package eegfd_pkg;

    localparam int DATA_LEN     = 30;
    localparam int FRAME_LEN    = 32;
    localparam int NUM_TRIPLES  = DATA_LEN / 3;
    localparam int NUM_CHANNELS = 2 * NUM_TRIPLES;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 5;
    localparam int ADDR_W = $clog2(DATA_LEN);
    localparam int TRI_W  = $clog2(NUM_TRIPLES);
    localparam int CH_W   = TRI_W + 1;
    localparam int MAG_W  = 11;
    localparam int VAL_W  = 12;
    localparam int TDATA_W = 24;

    localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hA0;

    typedef struct packed {
        logic pos_clear;
        logic pos_inc;
        logic mem_we;
        logic dec_start;
        logic rd_issue;
        logic cap_b0;
        logic cap_b1;
        logic cap_b2;
        logic load_even;
        logic load_odd;
        logic tri_inc;
    } cmd_t;

    typedef struct packed {
        logic hdr_match;
        logic pos_data;
        logic pos_trailer;
        logic out_free;
        logic tri_last;
    } status_t;

    function automatic logic signed [VAL_W-1:0] sm_to_value(
        input logic [MAG_W-1:0] mag,
        input logic             neg
    );
        logic signed [VAL_W-1:0] ext;
        ext = signed'({1'b0, mag});
        return neg ? -ext : ext;
    endfunction

endpackage

/* design/eegfd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module eegfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 30
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/eegfd_datapath.sv */
// Datapath: frame position counter, frame byte store, triple unpacking and output register.
module eegfd_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  eegfd_pkg::cmd_t                  cmd,
    output eegfd_pkg::status_t               status,
    input  logic [eegfd_pkg::BYTE_W-1:0]     s_tdata_byte,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [eegfd_pkg::CH_W-1:0]       out_index,
    output logic signed [eegfd_pkg::VAL_W-1:0] out_value,
    output logic                             out_last
);

    logic [eegfd_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [eegfd_pkg::ADDR_W-1:0] rd_addr_reg, rd_addr_next;
    logic [eegfd_pkg::TRI_W-1:0]  tri_reg, tri_next;
    logic [eegfd_pkg::BYTE_W-1:0] b0_reg, b1_reg, b2_reg;
    logic [eegfd_pkg::BYTE_W-1:0] rd_data;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [eegfd_pkg::CH_W-1:0]   index_reg;
    logic signed [eegfd_pkg::VAL_W-1:0] value_reg;
    logic                         last_reg;
    logic signed [eegfd_pkg::VAL_W-1:0] even_value, odd_value;

    eegfd_ram #(
        .WIDTH(eegfd_pkg::BYTE_W),
        .DEPTH(eegfd_pkg::DATA_LEN)
    ) u_frame_ram (
        .aclk   (aclk),
        .wr_en  (cmd.mem_we),
        .wr_addr(pos_reg[eegfd_pkg::ADDR_W-1:0]),
        .wr_data(s_tdata_byte),
        .rd_addr(rd_addr_reg),
        .rd_data(rd_data)
    );

    always_comb begin
        pos_next = pos_reg;
        if (cmd.pos_clear) begin
            pos_next = '0;
        end else if (cmd.pos_inc) begin
            pos_next = pos_reg + 1'b1;
        end
        rd_addr_next = rd_addr_reg;
        if (cmd.dec_start) begin
            rd_addr_next = '0;
        end else if (cmd.rd_issue) begin
            rd_addr_next = rd_addr_reg + 1'b1;
        end
        tri_next = tri_reg;
        if (cmd.dec_start) begin
            tri_next = '0;
        end else if (cmd.tri_inc) begin
            tri_next = tri_reg + 1'b1;
        end
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_even || cmd.load_odd) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            rd_addr_reg  <= '0;
            tri_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            rd_addr_reg  <= rd_addr_next;
            tri_reg      <= tri_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign even_value = eegfd_pkg::sm_to_value({b1_reg[2:0], b0_reg}, b1_reg[3]);
    assign odd_value  = eegfd_pkg::sm_to_value({b2_reg[6:0], b1_reg[7:4]}, b2_reg[7]);

    always_ff @(posedge aclk) begin
        if (cmd.cap_b0) begin
            b0_reg <= rd_data;
        end
        if (cmd.cap_b1) begin
            b1_reg <= rd_data;
        end
        if (cmd.cap_b2) begin
            b2_reg <= rd_data;
        end
        if (cmd.load_even) begin
            index_reg <= {tri_reg, 1'b0};
            value_reg <= even_value;
            last_reg  <= 1'b0;
        end else if (cmd.load_odd) begin
            index_reg <= {tri_reg, 1'b1};
            value_reg <= odd_value;
            last_reg  <= status.tri_last;
        end
    end

    assign status.hdr_match   = (s_tdata_byte == eegfd_pkg::HDR_BYTE);
    assign status.pos_data    = (pos_reg < eegfd_pkg::POS_W'(eegfd_pkg::DATA_LEN));
    assign status.pos_trailer = (pos_reg == eegfd_pkg::POS_W'(eegfd_pkg::FRAME_LEN - 1));
    assign status.out_free    = !m_tvalid_reg || m_tready;
    assign status.tri_last    = (tri_reg == eegfd_pkg::TRI_W'(eegfd_pkg::NUM_TRIPLES - 1));

    assign m_tvalid  = m_tvalid_reg;
    assign out_index = index_reg;
    assign out_value = value_reg;
    assign out_last  = last_reg;

endmodule

/* design/eegfd_ctrl.sv */
// Controller: header hunt, frame collection and per-triple decode sequencing.
module eegfd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  eegfd_pkg::status_t status,
    output eegfd_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_HUNT    = 3'd0;
    localparam logic [2:0] ST_COLLECT = 3'd1;
    localparam logic [2:0] ST_RD0     = 3'd2;
    localparam logic [2:0] ST_RD1     = 3'd3;
    localparam logic [2:0] ST_RD2     = 3'd4;
    localparam logic [2:0] ST_CAP2    = 3'd5;
    localparam logic [2:0] ST_EVEN    = 3'd6;
    localparam logic [2:0] ST_ODD     = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       in_fire;

    assign s_tready = (state_reg == ST_HUNT) || (state_reg == ST_COLLECT);
    assign in_fire  = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_HUNT: begin
                if (in_fire && status.hdr_match) begin
                    cmd.pos_clear = 1'b1;
                    state_next    = ST_COLLECT;
                end
            end
            ST_COLLECT: begin
                if (in_fire) begin
                    if (status.pos_data) begin
                        cmd.mem_we  = 1'b1;
                        cmd.pos_inc = 1'b1;
                    end else if (!status.pos_trailer) begin
                        cmd.pos_inc = 1'b1;
                    end else begin
                        cmd.pos_clear = 1'b1;
                        if (status.hdr_match) begin
                            cmd.dec_start = 1'b1;
                            state_next    = ST_RD0;
                        end else begin
                            state_next = ST_HUNT;
                        end
                    end
                end
            end
            ST_RD0: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_RD1;
            end
            ST_RD1: begin
                cmd.rd_issue = 1'b1;
                cmd.cap_b0   = 1'b1;
                state_next   = ST_RD2;
            end
            ST_RD2: begin
                cmd.rd_issue = 1'b1;
                cmd.cap_b1   = 1'b1;
                state_next   = ST_CAP2;
            end
            ST_CAP2: begin
                cmd.cap_b2 = 1'b1;
                state_next = ST_EVEN;
            end
            ST_EVEN: begin
                if (status.out_free) begin
                    cmd.load_even = 1'b1;
                    state_next    = ST_ODD;
                end
            end
            ST_ODD: begin
                if (status.out_free) begin
                    cmd.load_odd = 1'b1;
                    cmd.tri_inc  = 1'b1;
                    state_next   = status.tri_last ? ST_COLLECT : ST_RD0;
                end
            end
            default: begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/eeg_frame_deframer_unpacker.sv */
// Top level of the EEG frame deframer and channel unpacker.
// Takes one serial byte per item, hunts for the 0xA0 header and collects 32-byte
// frames; a frame whose byte 31 is 0xA0 is accepted and that byte starts the next
// frame, otherwise the block drops back to hunting. While hunting or collecting a
// byte is taken every cycle. After an accepted trailer, s_tready stays low while
// the ten stored triples are read back from the 30-entry frame RAM and unpacked
// into twenty channel items: each triple's three bytes are fetched in turn through
// the single registered read port (states RD0, RD1, RD2, CAP2), then its even and
// odd channel items are loaded into the output register, each waiting while the
// sink stalls. The last channel of a frame carries m_tlast.
module eeg_frame_deframer_unpacker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [4:0] channel_index, [16:5] channel_value, [23:17] zero
    output logic        m_tlast
);

    eegfd_pkg::cmd_t    cmd;
    eegfd_pkg::status_t status;
    logic [eegfd_pkg::CH_W-1:0]         out_index;
    logic signed [eegfd_pkg::VAL_W-1:0] out_value;
    logic                               out_last;

    eegfd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    eegfd_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_tdata_byte(s_tdata),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .out_index   (out_index),
        .out_value   (out_value),
        .out_last    (out_last)
    );

    assign m_tdata = {
        (eegfd_pkg::TDATA_W - eegfd_pkg::CH_W - eegfd_pkg::VAL_W)'(0),
        out_value,
        out_index
    };
    assign m_tlast = out_last;

`ifndef ASSERT_OFF
    a_store_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_we |-> (s_tvalid && s_tready && status.pos_data))
        else $error("frame byte stored without an accepted item");

    a_decode_on_good_trailer: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.dec_start |-> (s_tvalid && s_tready && status.hdr_match && status.pos_trailer))
        else $error("decode started without a valid trailer");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_even || cmd.load_odd) |-> (!m_tvalid || m_tready))
        else $error("output register overwritten while stalled");

    a_last_is_final_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[4:0] == 5'(eegfd_pkg::NUM_CHANNELS - 1)))
        else $error("last marker on a channel other than the final one");
`endif

endmodule

/* tb/sv/eeg_frame_deframer_unpacker_tb.sv */
// Testbench for the EEG frame deframer and channel unpacker: random byte stream in, checked channels out.
module eeg_frame_deframer_unpacker_tb;

    localparam int TAIL_LEN    = 64;
    localparam int NUM_BYTES   = 280;
    localparam int HOLD_AT     = 120;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE      = 200;

    typedef struct packed {
        logic [eegfd_pkg::CH_W-1:0]         idx;
        logic signed [eegfd_pkg::VAL_W-1:0] val;
        logic                               last;
    } chan_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] data_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // [4:0] channel_index, [16:5] channel_value, [23:17] zero
    logic        m_tlast;

    logic [7:0]  byte_q[$];
    chan_t       chan_q[$];
    int          src_gap;
    int          snk_gap;
    int          hold_left;
    bit          hold_done;
    int          bytes_in;
    int          err_cnt;

    bit          sync_seen;
    logic [4:0]  frame_pos;
    logic [7:0]  frame_mem[eegfd_pkg::DATA_LEN];

    eeg_frame_deframer_unpacker i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        err_cnt++;
        $display("mismatch: %s", msg);
    endtask

    task automatic put_byte(input logic [7:0] b);
        byte_q.insert(byte_q.size(), b);
    endtask

    task automatic put_chan(input chan_t ch);
        chan_q.insert(chan_q.size(), ch);
    endtask

    function automatic logic signed [eegfd_pkg::VAL_W-1:0] signed_sample(
        input logic [eegfd_pkg::MAG_W-1:0] mag,
        input logic                        neg
    );
        if (neg && mag != '0) begin
            return ~{1'b0, mag} + 1'b1;
        end
        return {1'b0, mag};
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        logic [7:0] b0, b1, b2;
        chan_t      ch;
        if (!sync_seen) begin
            if (b == eegfd_pkg::HDR_BYTE) begin
                sync_seen = 1'b1;
                frame_pos = '0;
            end
        end else if (frame_pos < eegfd_pkg::DATA_LEN) begin
            frame_mem[frame_pos] = b;
            frame_pos++;
        end else if (frame_pos < eegfd_pkg::FRAME_LEN - 1) begin
            frame_pos++;
        end else begin
            frame_pos = '0;
            if (b == eegfd_pkg::HDR_BYTE) begin
                for (int t = 0; t < eegfd_pkg::DATA_LEN / 3; t++) begin
                    b0 = frame_mem[3*t];
                    b1 = frame_mem[3*t + 1];
                    b2 = frame_mem[3*t + 2];
                    ch.idx  = eegfd_pkg::CH_W'(2*t);
                    ch.val  = signed_sample({b1[2:0], b0}, b1[3]);
                    ch.last = 1'b0;
                    put_chan(ch);
                    ch.idx  = eegfd_pkg::CH_W'(2*t + 1);
                    ch.val  = signed_sample({b2[6:0], b1[7:4]}, b2[7]);
                    ch.last = (2*t + 1 == eegfd_pkg::NUM_CHANNELS - 1);
                    put_chan(ch);
                end
            end else begin
                sync_seen = 1'b0;
            end
        end
    endtask

    function automatic logic [7:0] non_header_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 254));
        if (b >= eegfd_pkg::HDR_BYTE) begin
            b++;
        end
        return b;
    endfunction

    task automatic queue_noise(input int n);
        for (int i = 0; i < n; i++) begin
            put_byte(non_header_byte());
        end
    endtask

    task automatic queue_frame(input bit good_trailer);
        for (int i = 0; i < eegfd_pkg::FRAME_LEN - 1; i++) begin
            put_byte(8'($urandom_range(0, 255)));
        end
        put_byte(good_trailer ? eegfd_pkg::HDR_BYTE : non_header_byte());
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            src_gap  <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (src_gap != 0) begin
                s_tvalid <= 1'b0;
                src_gap  <= src_gap - 1;
            end else if (byte_q.size() != 0) begin
                s_tdata  <= byte_q.pop_front();
                s_tvalid <= 1'b1;
                if (byte_q.size() >= TAIL_LEN && $urandom_range(0, 5) == 0) begin
                    src_gap <= $urandom_range(1, 8);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && bytes_in >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            snk_gap  <= 0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
        end else if (snk_gap != 0) begin
            m_tready <= 1'b0;
            snk_gap  <= snk_gap - 1;
        end else begin
            m_tready <= 1'b1;
            if (byte_q.size() >= TAIL_LEN && $urandom_range(0, 4) == 0) begin
                snk_gap <= $urandom_range(1, 8);
            end
        end
    end

    always @(posedge aclk) begin
        chan_t                              exp_ch;
        logic [eegfd_pkg::CH_W-1:0]         got_idx;
        logic signed [eegfd_pkg::VAL_W-1:0] got_val;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                bytes_in++;
                deframe_byte(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                got_idx = m_tdata[eegfd_pkg::CH_W-1:0];
                got_val = m_tdata[eegfd_pkg::CH_W +: eegfd_pkg::VAL_W];
                if (chan_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected channel %0d value %0d",
                                              got_idx, got_val));
                end else begin
                    exp_ch = chan_q.pop_front();
                    if (got_idx !== exp_ch.idx) begin
                        report_mismatch($sformatf("channel_index %0d, want %0d",
                                                  got_idx, exp_ch.idx));
                    end
                    if (got_val !== exp_ch.val) begin
                        report_mismatch($sformatf("channel %0d value %0d, want %0d",
                                                  exp_ch.idx, got_val, exp_ch.val));
                    end
                    if (m_tlast !== exp_ch.last) begin
                        report_mismatch($sformatf("channel %0d tlast %b, want %b",
                                                  exp_ch.idx, m_tlast, exp_ch.last));
                    end
                end
            end
        end
    end

    initial begin
        logic [7:0] known_frame[eegfd_pkg::FRAME_LEN] = '{
            8'h00, 8'h08, 8'h80,  8'hFF, 8'h07, 8'h00,  8'hFF, 8'h0F, 8'hFF,
            8'h00, 8'hF0, 8'h7F,  8'h01, 8'hF8, 8'hFF,  8'hA0, 8'hA0, 8'hA0,
            8'h55, 8'hAA, 8'h55,  8'hAA, 8'h55, 8'hAA,  8'h12, 8'h34, 8'h56,
            8'h00, 8'h00, 8'h00,  8'hA0, 8'hA0
        };
        bit  gen_sync;
        int  wait_cnt;
        sync_seen   = 1'b0;
        frame_pos   = '0;
        bytes_in    = 0;
        err_cnt     = 0;

        // drop noise, sync, then a frame of extremes that is accepted
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'hA1);
        put_byte(eegfd_pkg::HDR_BYTE);
        foreach (known_frame[i]) begin
            put_byte(known_frame[i]);
        end
        // bad trailer 0xA1, one bit off the header, then 0x20, one bit off in the top bit
        queue_frame(1'b1);
        byte_q[byte_q.size() - 1] = 8'hA1;
        put_byte(eegfd_pkg::HDR_BYTE);
        queue_frame(1'b0);
        byte_q[byte_q.size() - 1] = 8'h20;
        gen_sync = 1'b0;

        while (byte_q.size() < NUM_BYTES) begin
            if (!gen_sync) begin
                queue_noise($urandom_range(0, 4));
                put_byte(eegfd_pkg::HDR_BYTE);
                gen_sync = 1'b1;
            end
            if ($urandom_range(0, 7) == 0) begin
                queue_frame(1'b0);
                gen_sync = 1'b0;
            end else begin
                queue_frame(1'b1);
            end
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        @(posedge aclk);
        while (byte_q.size() != 0 || s_tvalid) begin
            @(posedge aclk);
        end
        wait_cnt = 0;
        while (chan_q.size() != 0 && wait_cnt < DRAIN_LIMIT) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (SETTLE) @(posedge aclk);
        if (chan_q.size() != 0) begin
            report_mismatch($sformatf("%0d channels never arrived", chan_q.size()));
        end

        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
design/eegfd_pkg.sv
design/eegfd_ram.sv
design/eegfd_datapath.sv
design/eegfd_ctrl.sv
design/eeg_frame_deframer_unpacker.sv
tb/sv/eeg_frame_deframer_unpacker_tb.sv
